### rtl/rbd_pkg.sv
// Package for the ring buffer deque: field widths, opcodes, status codes and defaults.
`default_nettype none

package rbd_pkg;

	localparam int DEF_SLOTS     = 16;
	localparam int DEF_ELEM_BITS = 32;

	localparam int CAP_W    = 4;
	localparam int OPC_W    = 3;
	localparam int VAL_W    = 32;
	localparam int OFF_W    = 4;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 4;
	localparam int IN_BITS  = OPC_W + VAL_W + OFF_W;
	localparam int OUT_BITS = STAT_W + VAL_W + OCC_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH_LEFT  = 3'd0,
		OP_PUSH_RIGHT = 3'd1,
		OP_POP_LEFT   = 3'd2,
		OP_POP_RIGHT  = 3'd3,
		OP_READ_LEFT  = 3'd4,
		OP_READ_RIGHT = 3'd5
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

`default_nettype wire

### rtl/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/ring_buffer_deque.sv
// Ring buffer deque: a double-ended queue of up to capacity elements in a circular RAM.
// One beat is taken per clock cycle unless the output stalls; each result passes through the
// RAM read register and then the output register. Pointers and the count are updated in the
// accept cycle, so a pop or read issued right after a push sees the new entry through the RAM.
// Writing capacity empties the deque; element contents stay. The RAM depth is min(SLOTS, 16)
// entries, at most min(SLOTS - 1, 15) usable; the ring modulus is effective capacity plus one.
`default_nettype none

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int SLOTS     = DEF_SLOTS,
	parameter int ELEM_BITS = DEF_ELEM_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,   // opcode, push_value, offset, zero pad
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [OUT_W-1:0]  m_tdata,   // status, read_value, occupancy, zero pad
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata  // capacity
);

	localparam int CAP_MAX = (SLOTS - 1 < 15) ? SLOTS - 1 : 15;
	localparam int DEPTH   = CAP_MAX + 1;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int SUM_W   = CAP_W + 1;

	// registers
	logic [CAP_W-1:0]  cap_q;
	logic [PTR_W-1:0]  lp_q, rp_q;
	logic [OCC_W-1:0]  cnt_q;
	logic              valid_s1;
	logic              use_rd_s1;
	status_t           status_s1;
	logic [OCC_W-1:0]  occ_s1;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// input fields
	opcode_t           op;
	logic [VAL_W-1:0]  push_value;
	logic [OFF_W-1:0]  offset;

	logic              acc, out_free, s1_adv;
	logic [CAP_W-1:0]  cap_eff;
	logic [SUM_W-1:0]  m5, lp5, rp5, off5;
	logic [SUM_W-1:0]  lp_dec, rp_dec, lp_inc, rp_inc, rdl_sum, rdr_sum, rdl_idx, rdr_idx;

	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr, ram_raddr;
	logic [ELEM_BITS-1:0] ram_wdata, ram_rdata;

	status_t           nx_status;
	logic              nx_use_rd;
	logic [PTR_W-1:0]  nx_lp, nx_rp;
	logic [OCC_W-1:0]  nx_cnt;
	logic [VAL_W-1:0]  rd_val;

	assign op         = opcode_t'(s_tdata[OPC_W-1:0]);
	assign push_value = s_tdata[OPC_W+VAL_W-1:OPC_W];
	assign offset     = s_tdata[OPC_W+VAL_W+OFF_W-1:OPC_W+VAL_W];

	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || s1_adv;
	assign acc      = s_tvalid && s_tready;

	assign cap_eff = (cap_q > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : cap_q;
	assign m5      = SUM_W'(cap_eff) + SUM_W'(1);
	assign lp5     = SUM_W'(lp_q);
	assign rp5     = SUM_W'(rp_q);
	assign off5    = SUM_W'(offset);

	// wraps: for in-range offsets every operand stays below twice the modulus
	assign lp_dec  = (lp_q == '0) ? SUM_W'(cap_eff) : lp5 - SUM_W'(1);
	assign rp_dec  = (rp_q == '0) ? SUM_W'(cap_eff) : rp5 - SUM_W'(1);
	assign lp_inc  = (lp5 + SUM_W'(1) >= m5) ? '0 : lp5 + SUM_W'(1);
	assign rp_inc  = (rp5 + SUM_W'(1) >= m5) ? '0 : rp5 + SUM_W'(1);
	assign rdl_sum = lp5 + off5;
	assign rdl_idx = (rdl_sum >= m5) ? rdl_sum - m5 : rdl_sum;
	assign rdr_sum = rp5 + m5 - off5 - SUM_W'(1);
	assign rdr_idx = (rdr_sum >= m5) ? rdr_sum - m5 : rdr_sum;

	always_comb begin
		nx_status = ST_OK;
		nx_use_rd = 1'b0;
		nx_lp     = lp_q;
		nx_rp     = rp_q;
		nx_cnt    = cnt_q;
		ram_we    = 1'b0;
		ram_waddr = rp_q;
		ram_raddr = lp_q;
		unique case (op)
			OP_PUSH_LEFT: begin
				ram_waddr = PTR_W'(lp_dec);
				if (cnt_q >= cap_eff) begin
					nx_status = ST_FULL;
				end else begin
					ram_we = acc;
					nx_lp  = PTR_W'(lp_dec);
					nx_cnt = cnt_q + OCC_W'(1);
				end
			end
			OP_PUSH_RIGHT: begin
				ram_waddr = rp_q;
				if (cnt_q >= cap_eff) begin
					nx_status = ST_FULL;
				end else begin
					ram_we = acc;
					nx_rp  = PTR_W'(rp_inc);
					nx_cnt = cnt_q + OCC_W'(1);
				end
			end
			OP_POP_LEFT: begin
				ram_raddr = lp_q;
				if (cnt_q == '0) begin
					nx_status = ST_EMPTY;
				end else begin
					nx_use_rd = 1'b1;
					nx_lp     = PTR_W'(lp_inc);
					nx_cnt    = cnt_q - OCC_W'(1);
				end
			end
			OP_POP_RIGHT: begin
				ram_raddr = PTR_W'(rp_dec);
				if (cnt_q == '0) begin
					nx_status = ST_EMPTY;
				end else begin
					nx_use_rd = 1'b1;
					nx_rp     = PTR_W'(rp_dec);
					nx_cnt    = cnt_q - OCC_W'(1);
				end
			end
			OP_READ_LEFT: begin
				ram_raddr = PTR_W'(rdl_idx);
				if (offset >= cnt_q) nx_status = ST_RANGE;
				else nx_use_rd = 1'b1;
			end
			OP_READ_RIGHT: begin
				ram_raddr = PTR_W'(rdr_idx);
				if (offset >= cnt_q) nx_status = ST_RANGE;
				else nx_use_rd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ram_wdata = ELEM_BITS'(push_value);

	rbd_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			lp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
			lp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			lp_q  <= nx_lp;
			rp_q  <= nx_rp;
			cnt_q <= nx_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			use_rd_s1 <= nx_use_rd;
			status_s1 <= nx_status;
			occ_s1    <= nx_cnt;
		end
	end

	assign rd_val = use_rd_s1 ? VAL_W'(ram_rdata) : '0;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= OUT_W'({occ_s1, rd_val, status_s1});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// count never exceeds the effective capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_eff)
		else $error("element count above capacity");

	// an accepted push that is not full, with no capacity write, grows the count by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !cfg_we && (op == OP_PUSH_LEFT || op == OP_PUSH_RIGHT) && cnt_q < cap_eff
		|=> cnt_q == $past(cnt_q) + OCC_W'(1))
		else $error("push did not advance count");

	// read data is only returned with an ok status
	a_rd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && use_rd_s1 |-> status_s1 == ST_OK)
		else $error("read data flagged with error status");

	// a held result stage stays put while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(occ_s1))
		else $error("pending beat lost under back-pressure");

endmodule

`default_nettype wire

### sim/ring_buffer_deque_tb.sv
// Self-checking testbench for the ring buffer deque: directed cases and random stream traffic against a predictor.
`timescale 1ns / 100ps

module ring_buffer_deque_tb;
	import rbd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 120;

	// opcodes the block treats as no-ops
	localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;

	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [VAL_W-1:0] push_value;
		logic [OPC_W-1:0] opcode;
	} deque_op_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] read_value;
		logic [OCC_W-1:0] occupancy;
	} deque_reply_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;   // opcode, push_value, offset, zero pad
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;          // status, read_value, occupancy, zero pad
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;   // capacity

	ring_buffer_deque DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [VAL_W-1:0] ring [DEF_SLOTS];
	int model_cap   = CAP_RESET;
	int model_left  = 0;
	int model_right = 0;
	int model_cnt   = 0;

	deque_op_t    op_backlog[$];
	deque_reply_t deque_replies[$];
	deque_op_t    in_flight;

	int mismatches  = 0;
	int cycle_count = 0;
	int send_gap    = 0;
	int burst_left  = 0;
	bit no_gaps     = 1'b0;
	int hold_req    = 0;
	int hold_done   = 0;
	int hold_left   = 0;
	int stall_left  = 0;
	int flow_left   = 0;

	function automatic int ring_wrap(int v, int m);
		return (v >= m) ? v - m : v;
	endfunction

	function automatic deque_reply_t deque_apply(deque_op_t op);
		deque_reply_t r;
		int m;
		int idx;
		m = model_cap + 1;
		r.status = ST_OK;
		r.read_value = '0;
		case (op.opcode)
			OP_PUSH_LEFT, OP_PUSH_RIGHT: begin
				if (model_cnt >= model_cap) begin
					r.status = ST_FULL;
				end else if (op.opcode == OP_PUSH_LEFT) begin
					idx = ring_wrap(model_left + m - 1, m);
					ring[idx] = op.push_value;
					model_left = idx;
					model_cnt++;
				end else begin
					ring[model_right] = op.push_value;
					model_right = ring_wrap(model_right + 1, m);
					model_cnt++;
				end
			end
			OP_POP_LEFT, OP_POP_RIGHT: begin
				if (model_cnt == 0) begin
					r.status = ST_EMPTY;
				end else if (op.opcode == OP_POP_LEFT) begin
					r.read_value = ring[model_left];
					model_left = ring_wrap(model_left + 1, m);
					model_cnt--;
				end else begin
					idx = ring_wrap(model_right + m - 1, m);
					r.read_value = ring[idx];
					model_right = idx;
					model_cnt--;
				end
			end
			OP_READ_LEFT, OP_READ_RIGHT: begin
				if (int'(op.offset) >= model_cnt) begin
					r.status = ST_RANGE;
				end else if (op.opcode == OP_READ_LEFT) begin
					r.read_value = ring[ring_wrap(model_left + int'(op.offset), m)];
				end else begin
					r.read_value = ring[ring_wrap(model_right + m - int'(op.offset) - 1, m)];
				end
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(model_cnt);
		return r;
	endfunction

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	function automatic int next_send_gap();
		if (no_gaps)
			return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 59) == 0)
			burst_left = 30;
		if ($urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// source side
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				deque_replies.push_back(deque_apply(in_flight));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (op_backlog.size() > 0) begin
					in_flight = op_backlog.pop_front();
					s_tdata   <= {{(IN_W - IN_BITS){1'b0}}, in_flight.offset,
						in_flight.push_value, in_flight.opcode};
					s_tvalid  <= 1'b1;
					send_gap  = next_send_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side back-pressure; a requested hold stalls the output for a long stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (flow_left > 0) begin
				flow_left--;
				m_tready <= 1'b1;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:1]:   begin flow_left = 40; m_tready <= 1'b1; end
					[2:24]:  begin stall_left = idle_len() - 1; m_tready <= 1'b0; end
					default: m_tready <= 1'b1;
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		deque_reply_t want;
		logic [STAT_W-1:0] got_status;
		logic [VAL_W-1:0]  got_value;
		logic [OCC_W-1:0]  got_occ;
		if (arst_n && m_tvalid && m_tready) begin
			got_status = m_tdata[STAT_W-1:0];
			got_value  = m_tdata[STAT_W +: VAL_W];
			got_occ    = m_tdata[STAT_W + VAL_W +: OCC_W];
			if (deque_replies.size() == 0) begin
				mismatches++;
				$error("result beat with none outstanding: status %0d value %h occupancy %0d",
					got_status, got_value, got_occ);
			end else begin
				want = deque_replies.pop_front();
				if (got_status !== want.status) begin
					mismatches++;
					$error("status: expected %0d, got %0d", want.status, got_status);
				end
				if (got_value !== want.read_value) begin
					mismatches++;
					$error("read_value: expected %h, got %h", want.read_value, got_value);
				end
				if (got_occ !== want.occupancy) begin
					mismatches++;
					$error("occupancy: expected %0d, got %0d", want.occupancy, got_occ);
				end
			end
		end
	end

	task automatic add_op(logic [OPC_W-1:0] opc, logic [VAL_W-1:0] val, logic [OFF_W-1:0] off);
		deque_op_t op;
		op.opcode     = opc;
		op.push_value = val;
		op.offset     = off;
		op_backlog.push_back(op);
	endtask

	// sampled mid-cycle so the driver's and checker's updates have all landed
	task automatic settle();
		while (op_backlog.size() != 0 || deque_replies.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// a capacity write also empties the deque
	task automatic set_capacity(int cap);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CAP_W'(cap);
		@(posedge clk);
		cfg_we      <= 1'b0;
		model_cap   = cap;
		model_left  = 0;
		model_right = 0;
		model_cnt   = 0;
		@(posedge clk);
	endtask

	function automatic deque_op_t random_op(int mode);
		deque_op_t op;
		int r;
		int push_w;
		int pop_w;
		push_w = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 15 : 35;
		pop_w  = (mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 55 : 35;
		r = $urandom_range(0, 99);
		if (r < push_w)
			op.opcode = $urandom_range(0, 1) ? OP_PUSH_RIGHT : OP_PUSH_LEFT;
		else if (r < push_w + pop_w)
			op.opcode = $urandom_range(0, 1) ? OP_POP_RIGHT : OP_POP_LEFT;
		else if (r < 98)
			op.opcode = $urandom_range(0, 1) ? OP_READ_RIGHT : OP_READ_LEFT;
		else
			op.opcode = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
		case ($urandom_range(0, 9))
			0:       op.push_value = '0;
			1:       op.push_value = '1;
			default: op.push_value = $urandom;
		endcase
		if ($urandom_range(0, 9) < 7)
			op.offset = $urandom_range(0, model_cap);
		else
			op.offset = $urandom_range(0, 15);
		return op;
	endfunction

	task automatic run_phase(int cap, int n, bit squeeze);
		int mode;
		set_capacity(cap);
		if (squeeze) begin
			no_gaps = 1'b1;
			hold_req++;
		end
		mode = MODE_FILL;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 39)
				mode = $urandom_range(MODE_FILL, MODE_MIXED);
			op_backlog.push_back(random_op(mode));
		end
		settle();
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: empty-end cases, both ends, reads from both sides, spare opcodes
		add_op(OP_POP_LEFT, '0, '0);
		add_op(OP_POP_RIGHT, '0, '0);
		add_op(OP_READ_LEFT, '0, '0);
		add_op(OP_PUSH_LEFT, 32'h0000_0000, '0);
		add_op(OP_PUSH_RIGHT, 32'hFFFF_FFFF, '0);
		add_op(OP_PUSH_LEFT, 32'hA5A5_A5A5, '1);
		add_op(OP_READ_LEFT, '0, 4'd0);
		add_op(OP_READ_RIGHT, '0, 4'd0);
		add_op(OP_READ_LEFT, '0, 4'd2);
		add_op(OP_READ_RIGHT, '0, 4'd1);
		add_op(OP_READ_LEFT, '0, 4'd3);
		add_op(OP_READ_RIGHT, '0, 4'd15);
		add_op(OP_SPARE_6, 32'h1234_5678, 4'd15);
		add_op(OP_SPARE_7, 32'hFFFF_FFFF, 4'd0);
		add_op(OP_POP_RIGHT, '0, '0);
		add_op(OP_POP_LEFT, '0, '0);
		add_op(OP_POP_LEFT, '0, '0);
		add_op(OP_POP_RIGHT, '0, '0);
		settle();

		// full on push, left over entry cleared by the next capacity write
		set_capacity(2);
		add_op(OP_PUSH_RIGHT, 32'h5A5A_5A5A, '0);
		add_op(OP_PUSH_RIGHT, 32'hDEAD_BEEF, '0);
		add_op(OP_PUSH_LEFT, 32'h0F0F_0F0F, '0);
		add_op(OP_POP_LEFT, '0, '0);
		settle();

		// zero capacity: always full
		set_capacity(0);
		add_op(OP_PUSH_LEFT, 32'h1111_1111, '0);
		add_op(OP_PUSH_RIGHT, 32'h2222_2222, '0);
		add_op(OP_POP_LEFT, '0, '0);
		add_op(OP_READ_RIGHT, '0, 4'd0);
		settle();

		run_phase(15, 200, 1'b0);
		run_phase(1, 60, 1'b0);
		run_phase(4, 120, 1'b0);
		run_phase(7, 100, 1'b1);
		run_phase($urandom_range(1, 15), 80, 1'b0);
		run_phase($urandom_range(1, 15), 60, 1'b0);
		run_phase(15, 30, 1'b0);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
